// File: rtl/lfw_pkg.sv
`timescale 1ns / 1ps
// lfw_pkg: constants shared by the line fold block and its channel interfaces.
// No dependencies.

package lfw_pkg;

    localparam int BYTE_W      = 8;
    localparam int ADDR_W      = 6;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int CFG_W       = 6;
    localparam int CFG_IDX_W   = 1;

    localparam logic [ADDR_W-1:0] MAX_WIDTH = 6'd63;

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [BYTE_W-1:0] SPACE_BYTE   = 8'h20;
    localparam logic [BYTE_W-1:0] TAB_BYTE     = 8'h09;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BREAK_AT_SPACE = 1'd1;

endpackage

// File: rtl/lfw_if.sv
`timescale 1ns / 1ps
// lfw_in_if / lfw_out_if: valid/ready channels for text bytes in and folded bytes out.
// Depends on lfw_pkg.

interface lfw_in_if import lfw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface lfw_out_if import lfw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// File: rtl/line_fold_wrapper.sv
`timescale 1ns / 1ps
// line_fold_wrapper: folds a byte stream into lines, segment kept in a 64-byte store.
// Depends on lfw_pkg and lfw_in_if / lfw_out_if.
//
//  channel    dir  payload                 request when
//  bytes      in   in_byte                 valid && ready
//  lines      out  out_byte, last_of_run   valid && ready
//  cfg        in   cfg_index, cfg_data     cfg_we
//
// A byte that causes no line is stored. A newline, or a byte that forces a break,
// sends the line's stored bytes, then a newline: the single store read port
// delivers one byte a cycle while the output queue has room. A 2-entry output
// queue absorbs downstream stalls. Reset leaves the store undefined; no clearing pass.

module line_fold_wrapper
    import lfw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    lfw_in_if.sink               bytes,
    lfw_out_if.source            lines,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic [BYTE_W-1:0] store_mem [STORE_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    logic              state_reg, state_next;
    logic [ADDR_W-1:0] start_reg, start_next;
    logic [ADDR_W-1:0] col_reg, col_next;
    logic [ADDR_W-1:0] bp_reg, bp_next;
    logic [ADDR_W-1:0] width_reg;
    logic              bas_reg;
    logic [ADDR_W-1:0] drain_addr_reg, drain_addr_next;
    logic [ADDR_W-1:0] drain_left_reg, drain_left_next;
    logic [BYTE_W-1:0] held_byte_reg, held_byte_next;
    logic              p_valid_reg, p_valid_next;
    logic              p_nl_reg, p_nl_next;

    logic [BYTE_W-1:0] q_byte_reg [2];
    logic              q_last_reg [2];
    logic              q_wptr_reg, q_rptr_reg;
    logic [1:0]        q_cnt_reg;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_wa, mem_ra;
    logic [BYTE_W-1:0] mem_wd;

    logic [ADDR_W-1:0] width_eff;
    logic              accept, pop, can_issue, is_nl, need_break;
    logic [1:0]        occ_after;
    logic [ADDR_W-1:0] cut;
    logic [BYTE_W-1:0] p_byte;

    always_comb
    begin
        if (width_reg == '0)
            width_eff = {{(ADDR_W-1){1'b0}}, 1'b1};
        else if (width_reg > MAX_WIDTH)
            width_eff = MAX_WIDTH;
        else
            width_eff = width_reg;
    end

    assign bytes.ready = (state_reg == ST_IDLE);
    assign accept      = bytes.valid && bytes.ready;
    assign is_nl       = (bytes.in_byte == NEWLINE_BYTE);
    assign need_break  = (col_reg >= width_eff);

    assign lines.valid       = (q_cnt_reg != 2'd0);
    assign lines.out_byte    = q_byte_reg[q_rptr_reg];
    assign lines.last_of_run = q_last_reg[q_rptr_reg];
    assign pop               = lines.valid && lines.ready;

    assign occ_after = q_cnt_reg + {1'b0, p_valid_reg} - {1'b0, pop};
    assign can_issue = (occ_after < 2'd2);
    assign p_byte    = p_nl_reg ? NEWLINE_BYTE : rd_data_reg;

    always_comb
    begin
        if (is_nl || !(bas_reg && bp_reg != '0))
            cut = col_reg;
        else
            cut = bp_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        start_next      = start_reg;
        col_next        = col_reg;
        bp_next         = bp_reg;
        drain_addr_next = drain_addr_reg;
        drain_left_next = drain_left_reg;
        held_byte_next  = held_byte_reg;
        p_valid_next    = 1'b0;
        p_nl_next       = p_nl_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_wa          = start_reg + col_reg;
        mem_ra          = drain_addr_reg;
        mem_wd          = held_byte_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_nl || need_break)
                    begin
                        drain_addr_next = start_reg;
                        drain_left_next = cut;
                        held_byte_next  = bytes.in_byte;
                        start_next      = start_reg + cut;
                        col_next        = col_reg - cut;
                        bp_next         = '0;
                        state_next      = ST_DRAIN;
                    end
                    else
                    begin
                        mem_we   = 1'b1;
                        mem_wd   = bytes.in_byte;
                        col_next = col_reg + ADDR_W'(1);
                        if (bytes.in_byte inside {SPACE_BYTE, TAB_BYTE})
                            bp_next = col_reg + ADDR_W'(1);
                    end
                end
            end
            ST_DRAIN:
            begin
                if (can_issue)
                begin
                    p_valid_next = 1'b1;
                    if (drain_left_reg != '0)
                    begin
                        mem_re          = 1'b1;
                        p_nl_next       = 1'b0;
                        drain_addr_next = drain_addr_reg + ADDR_W'(1);
                        drain_left_next = drain_left_reg - ADDR_W'(1);
                    end
                    else
                    begin
                        // final newline; the held byte, unless a newline, joins the carried-over segment
                        p_nl_next  = 1'b1;
                        state_next = ST_IDLE;
                        if (held_byte_reg != NEWLINE_BYTE)
                        begin
                            mem_we   = 1'b1;
                            col_next = col_reg + ADDR_W'(1);
                            if (held_byte_reg inside {SPACE_BYTE, TAB_BYTE})
                                bp_next = col_reg + ADDR_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_wa] <= mem_wd;
        if (mem_re)
            rd_data_reg <= store_mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            start_reg      <= '0;
            col_reg        <= '0;
            bp_reg         <= '0;
            width_reg      <= MAX_WIDTH;
            bas_reg        <= 1'b0;
            drain_addr_reg <= '0;
            drain_left_reg <= '0;
            p_valid_reg    <= 1'b0;
            p_nl_reg       <= 1'b0;
            q_wptr_reg     <= 1'b0;
            q_rptr_reg     <= 1'b0;
            q_cnt_reg      <= 2'd0;
        end
        else
        begin
            state_reg      <= state_next;
            start_reg      <= start_next;
            col_reg        <= col_next;
            bp_reg         <= bp_next;
            drain_addr_reg <= drain_addr_next;
            drain_left_reg <= drain_left_next;
            p_valid_reg    <= p_valid_next;
            p_nl_reg       <= p_nl_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LINE_WIDTH:     width_reg <= cfg_data;
                    REG_BREAK_AT_SPACE: bas_reg   <= cfg_data[0];
                    default:            ;
                endcase
            end
            if (p_valid_reg)
                q_wptr_reg <= ~q_wptr_reg;
            if (pop)
                q_rptr_reg <= ~q_rptr_reg;
            q_cnt_reg <= q_cnt_reg + {1'b0, p_valid_reg} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        held_byte_reg <= held_byte_next;
        if (p_valid_reg)
        begin
            q_byte_reg[q_wptr_reg] <= p_byte;
            q_last_reg[q_wptr_reg] <= p_nl_reg;
        end
    end

`ifndef SYNTHESIS
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg |-> (q_cnt_reg != 2'd2 || pop))
        else $error("output queue overflow");

    a_last_is_newline: assert property (@(posedge clk) disable iff (!rst_n)
        (lines.valid && lines.last_of_run) |-> (lines.out_byte == NEWLINE_BYTE))
        else $error("last byte of a run is not a newline");

    a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_nl && !need_break) |=> (col_reg == $past(col_reg) + ADDR_W'(1)))
        else $error("column count did not advance on append");

    a_no_read_on_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mem_re)
        else $error("store read outside a drain");

    a_drain_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (is_nl || need_break)) |=> !bytes.ready)
        else $error("input taken during a drain");
`endif

endmodule
